// ----- hdl/cilu_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Contact-process / Ising lattice update: shared definitions
// Site codes, register indexes and reset values, widths and the item and result payloads.
// ---------------------------------------------------------------------------
package cilu_pkg;

	localparam int COORD_W    = 8;
	localparam int ADDR_W     = 2 * COORD_W;
	localparam int SITE_COUNT = 1 << ADDR_W;
	localparam int COUNT_W    = 17;
	localparam int DRAW_W     = 32;
	localparam int REG_W      = 33;
	localparam int NUM_REGS   = 7;
	localparam int CFG_IDX_W  = 3;

	localparam logic [1:0] SITE_EMPTY  = 2'd0;
	localparam logic [1:0] SITE_UNDIFF = 2'd1;
	localparam logic [1:0] SITE_UP     = 2'd2;
	localparam logic [1:0] SITE_DOWN   = 2'd3;

	localparam logic KIND_ATTEMPT = 1'b0;
	localparam logic KIND_WRITE   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_BIRTH      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEATH      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIFF       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_ONE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_TWO   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_THREE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_FOUR  = 3'd6;

	localparam logic [REG_W-1:0] RST_BIRTH      = 33'd4294967296;
	localparam logic [REG_W-1:0] RST_DEATH      = 33'd0;
	localparam logic [REG_W-1:0] RST_DIFF       = 33'd4294967296;
	localparam logic [REG_W-1:0] RST_FLIP_ONE   = 33'd1779700000;
	localparam logic [REG_W-1:0] RST_FLIP_TWO   = 33'd737500000;
	localparam logic [REG_W-1:0] RST_FLIP_THREE = 33'd305600000;
	localparam logic [REG_W-1:0] RST_FLIP_FOUR  = 33'd126600000;

	typedef struct packed {
		logic              kind;
		logic [COORD_W-1:0] site_x;
		logic [COORD_W-1:0] site_y;
		logic [1:0]        neighbour_pick;
		logic [DRAW_W-1:0] first_draw;
		logic [DRAW_W-1:0] second_draw;
		logic              spin_bit;
		logic [1:0]        write_value;
	} item_t;

	typedef struct packed {
		logic [1:0]         new_site;
		logic               changed;
		logic [COUNT_W-1:0] occupied_total;
		logic [COUNT_W-1:0] up_total;
		logic [COUNT_W-1:0] down_total;
	} result_t;

endpackage

// ----- hdl/cilu_channels.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Contact-process / Ising lattice update: channel interfaces
// Valid/ready channels for attempt items and for result items.
// ---------------------------------------------------------------------------
interface cilu_in_if;
	import cilu_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cilu_out_if;
	import cilu_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/contact_ising_lattice_update_core.sv -----
`timescale 1ns / 1ps
// Each item passes S_READ, with five lattice reads on the one read port (focal site and
//   four neighbours), then S_WAIT, S_DECIDE and S_WRITE before its result is registered.
// A new item is taken only in S_IDLE, after the last has left S_WRITE; it may be taken while a result waits.
// Reset: after arst_n releases, a clearing pass writes all 65536 sites empty
//   with input ready low; counts reset to zero, thresholds to defaults.
// ---------------------------------------------------------------------------
// Contact-process / Ising lattice update core
// Lattice in one synchronous memory; each item reads, decides and writes back at most once, only when the site changes.
// ---------------------------------------------------------------------------
module contact_ising_lattice_update_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cilu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cilu_pkg::REG_W-1:0]       cfg_data,
	cilu_in_if.sink                          attempt,
	cilu_out_if.source                       result
);
	import cilu_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_READ   = 6'b000100,
		S_WAIT   = 6'b001000,
		S_DECIDE = 6'b010000,
		S_WRITE  = 6'b100000
	} state_t;

	state_t state_q;

	logic [1:0]         lattice_mem [SITE_COUNT];
	logic [ADDR_W-1:0]  clr_addr_q;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  wr_addr;
	logic [1:0]         wr_data;
	logic               wr_en;
	logic [1:0]         rd_data_s1;
	logic [2:0]         rd_tag_s1;
	logic               rd_pend_s1;

	logic [REG_W-1:0]   thr_q [NUM_REGS];
	item_t              item_q;
	logic [2:0]         rd_cnt_q;
	logic [1:0]         focal_q;
	logic [1:0]         nbr_q [4];
	logic [1:0]         new_q;
	logic [1:0]         new_code;

	logic [COUNT_W-1:0] occ_q, up_q, down_q;
	logic [COUNT_W-1:0] occ_next, up_next, down_next;
	logic               res_valid_q;
	result_t            res_q;

	logic [COORD_W-1:0] xm, xp, ym, yp;
	logic               out_free;
	logic               accept;
	logic               changed;

	function automatic logic signed [3:0] spin_of(input logic [1:0] code);
		logic signed [3:0] v;
		v = 4'sd0;
		if (code == SITE_UP)
			v = 4'sd1;
		else if (code == SITE_DOWN)
			v = -4'sd1;
		return v;
	endfunction

	assign accept   = attempt.valid && attempt.ready;
	assign out_free = !res_valid_q || result.ready;
	assign attempt.ready = (state_q == S_IDLE);
	assign result.valid  = res_valid_q;
	assign result.data   = res_q;

	// Neighbour coordinates wrap through the natural width of the coordinate.
	assign xm = item_q.site_x - 1'b1;
	assign xp = item_q.site_x + 1'b1;
	assign ym = item_q.site_y - 1'b1;
	assign yp = item_q.site_y + 1'b1;

	// Read order: focal, y-1, y+1, x-1, x+1 (neighbour tag equals pick + 1).
	always_comb begin
		case (rd_cnt_q)
			3'd1:    rd_addr = {item_q.site_x, ym};
			3'd2:    rd_addr = {item_q.site_x, yp};
			3'd3:    rd_addr = {xm, item_q.site_y};
			3'd4:    rd_addr = {xp, item_q.site_y};
			default: rd_addr = {item_q.site_x, item_q.site_y};
		endcase
	end

	assign changed = (new_q != focal_q);

	always_comb begin
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = SITE_EMPTY;
		end else begin
			wr_en   = (state_q == S_WRITE) && out_free && changed;
			wr_addr = {item_q.site_x, item_q.site_y};
			wr_data = new_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			lattice_mem[wr_addr] <= wr_data;
		rd_data_s1 <= lattice_mem[rd_addr];
	end

	// Decision on the gathered sites.
	always_comb begin
		logic signed [3:0] sum;
		logic signed [3:0] k;
		logic [REG_W-1:0]  flip_thr;
		logic              death_pass;
		logic              flip;
		sum = spin_of(nbr_q[0]) + spin_of(nbr_q[1]) + spin_of(nbr_q[2]) + spin_of(nbr_q[3]);
		k   = (focal_q == SITE_UP) ? sum : -sum;
		death_pass = {1'b0, item_q.first_draw} < thr_q[REG_DEATH];
		case (k)
			4'sd1:   flip_thr = thr_q[REG_FLIP_ONE];
			4'sd2:   flip_thr = thr_q[REG_FLIP_TWO];
			4'sd3:   flip_thr = thr_q[REG_FLIP_THREE];
			4'sd4:   flip_thr = thr_q[REG_FLIP_FOUR];
			default: flip_thr = '0;
		endcase
		// A neutral or unfavorable alignment always flips unless the death test passes.
		flip = (k <= 4'sd0) || ({1'b0, item_q.second_draw} < flip_thr);
		new_code = focal_q;
		if (item_q.kind == KIND_WRITE) begin
			new_code = item_q.write_value;
		end else begin
			case (focal_q)
				SITE_EMPTY: begin
					if ({1'b0, item_q.first_draw} < thr_q[REG_BIRTH])
						new_code = nbr_q[item_q.neighbour_pick];
				end
				SITE_UNDIFF: begin
					if (death_pass)
						new_code = SITE_EMPTY;
					else if ({1'b0, item_q.second_draw} < thr_q[REG_DIFF])
						new_code = item_q.spin_bit ? SITE_UP : SITE_DOWN;
				end
				default: begin
					if (death_pass)
						new_code = SITE_EMPTY;
					else if (flip)
						new_code = (focal_q == SITE_UP) ? SITE_DOWN : SITE_UP;
				end
			endcase
		end
	end

	always_comb begin
		occ_next  = occ_q - COUNT_W'(focal_q != SITE_EMPTY) + COUNT_W'(new_q != SITE_EMPTY);
		up_next   = up_q - COUNT_W'(focal_q == SITE_UP) + COUNT_W'(new_q == SITE_UP);
		down_next = down_q - COUNT_W'(focal_q == SITE_DOWN) + COUNT_W'(new_q == SITE_DOWN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q[REG_BIRTH]      <= RST_BIRTH;
			thr_q[REG_DEATH]      <= RST_DEATH;
			thr_q[REG_DIFF]       <= RST_DIFF;
			thr_q[REG_FLIP_ONE]   <= RST_FLIP_ONE;
			thr_q[REG_FLIP_TWO]   <= RST_FLIP_TWO;
			thr_q[REG_FLIP_THREE] <= RST_FLIP_THREE;
			thr_q[REG_FLIP_FOUR]  <= RST_FLIP_FOUR;
		end else begin
			for (int i = 0; i < NUM_REGS; i++) begin
				if (cfg_we && cfg_index == CFG_IDX_W'(i))
					thr_q[i] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			rd_cnt_q    <= '0;
			rd_pend_s1  <= 1'b0;
			res_valid_q <= 1'b0;
			occ_q       <= '0;
			up_q        <= '0;
			down_q      <= '0;
		end else begin
			rd_pend_s1 <= (state_q == S_READ);
			if (state_q == S_WRITE && out_free)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (&clr_addr_q)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					rd_cnt_q <= '0;
					if (accept)
						state_q <= S_READ;
				end
				S_READ: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == 3'd4)
						state_q <= S_WAIT;
				end
				S_WAIT: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (out_free) begin
						occ_q   <= occ_next;
						up_q    <= up_next;
						down_q  <= down_next;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_tag_s1 <= rd_cnt_q;
		if (accept)
			item_q <= attempt.data;
		if (rd_pend_s1) begin
			if (rd_tag_s1 == 3'd0)
				focal_q <= rd_data_s1;
			else
				nbr_q[rd_tag_s1[1:0] - 2'd1] <= rd_data_s1;
		end
		if (state_q == S_DECIDE)
			new_q <= new_code;
		if (state_q == S_WRITE && out_free) begin
			res_q.new_site       <= new_q;
			res_q.changed        <= changed;
			res_q.occupied_total <= occ_next;
			res_q.up_total       <= up_next;
			res_q.down_total     <= down_next;
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Contact-process / Ising lattice update core: self-checking testbench
// Drives attempt and write items over the valid/ready input channel and
// predicts every result from its own copy of the lattice, the site counts
// and the threshold registers. Directed items cover the extremes, wrapping,
// each neighbour choice and the special rules. Random items then work a small
// window across the wrap corner under several threshold settings. Both
// channels idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;
	import cilu_pkg::*;

	localparam logic [1:0] NB_Y_MINUS = 2'd0;
	localparam logic [1:0] NB_Y_PLUS  = 2'd1;
	localparam logic [1:0] NB_X_MINUS = 2'd2;
	localparam logic [1:0] NB_X_PLUS  = 2'd3;

	localparam logic [REG_W-1:0]  ALWAYS_PASS = 33'h1_0000_0000;
	localparam logic [DRAW_W-1:0] DRAW_MAX    = 32'hFFFF_FFFF;
	localparam int RANDOM_PHASES   = 4;
	localparam int ITEMS_PER_PHASE = 205;
	localparam int SETTLE_CYCLES   = 20;
	localparam int LONG_HOLD       = 400;
	localparam int HOLD_AFTER      = 150;

	typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;

	cilu_in_if  attempt_ch();
	cilu_out_if result_ch();

	contact_ising_lattice_update_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.attempt   (attempt_ch),
		.result    (result_ch)
	);

	// Predicted block state.
	logic [1:0]         site_model [SITE_COUNT];
	logic [COUNT_W-1:0] occupied_model;
	logic [COUNT_W-1:0] up_model;
	logic [COUNT_W-1:0] down_model;
	logic [REG_W-1:0]   thresholds [NUM_REGS];

	item_t   queued_attempts[$];
	result_t expected_updates[$];
	int      mismatch_count = 0;
	int      results_seen = 0;
	logic    item_taken = 1'b0;

	int          burst_left = 0;
	int          gap_left = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          mode_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	logic [15:0] stall_pattern = 16'hFFFF;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int spin_of(input logic [1:0] code);
		if (code == SITE_UP)
			return 1;
		if (code == SITE_DOWN)
			return -1;
		return 0;
	endfunction

	// Applies one item to the predicted lattice and returns the expected result.
	function automatic result_t apply_site_rules(input item_t it);
		logic [COORD_W-1:0] xm, xp, ym, yp;
		logic [1:0]         old_code, new_code, nb;
		int                 k;
		result_t            r;
		xm = it.site_x - 8'd1;
		xp = it.site_x + 8'd1;
		ym = it.site_y - 8'd1;
		yp = it.site_y + 8'd1;
		old_code = site_model[{it.site_x, it.site_y}];
		new_code = old_code;
		if (it.kind == KIND_WRITE) begin
			new_code = it.write_value;
		end else if (old_code == SITE_EMPTY) begin
			case (it.neighbour_pick)
				NB_Y_MINUS: nb = site_model[{it.site_x, ym}];
				NB_Y_PLUS:  nb = site_model[{it.site_x, yp}];
				NB_X_MINUS: nb = site_model[{xm, it.site_y}];
				default:    nb = site_model[{xp, it.site_y}];
			endcase
			if ({1'b0, it.first_draw} < thresholds[REG_BIRTH])
				new_code = nb;
		end else if (old_code == SITE_UNDIFF) begin
			if ({1'b0, it.first_draw} < thresholds[REG_DEATH])
				new_code = SITE_EMPTY;
			else if ({1'b0, it.second_draw} < thresholds[REG_DIFF])
				new_code = it.spin_bit ? SITE_UP : SITE_DOWN;
		end else begin
			k = spin_of(old_code) * (spin_of(site_model[{it.site_x, ym}])
				+ spin_of(site_model[{it.site_x, yp}])
				+ spin_of(site_model[{xm, it.site_y}])
				+ spin_of(site_model[{xp, it.site_y}]));
			// Death is tested first; a neutral or unfavorable spin always flips.
			if ({1'b0, it.first_draw} < thresholds[REG_DEATH])
				new_code = SITE_EMPTY;
			else if (k <= 0 || {1'b0, it.second_draw} < thresholds[int'(REG_FLIP_ONE) + k - 1])
				new_code = (old_code == SITE_UP) ? SITE_DOWN : SITE_UP;
		end
		if (new_code != old_code) begin
			site_model[{it.site_x, it.site_y}] = new_code;
			if (old_code != SITE_EMPTY)
				occupied_model = occupied_model - 1'b1;
			if (old_code == SITE_UP)
				up_model = up_model - 1'b1;
			if (old_code == SITE_DOWN)
				down_model = down_model - 1'b1;
			if (new_code != SITE_EMPTY)
				occupied_model = occupied_model + 1'b1;
			if (new_code == SITE_UP)
				up_model = up_model + 1'b1;
			if (new_code == SITE_DOWN)
				down_model = down_model + 1'b1;
		end
		r.new_site       = new_code;
		r.changed        = (new_code != old_code);
		r.occupied_total = occupied_model;
		r.up_total       = up_model;
		r.down_total     = down_model;
		return r;
	endfunction

	task automatic queue_item(input logic kind, input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic [1:0] pick,
		input logic [DRAW_W-1:0] d1, input logic [DRAW_W-1:0] d2,
		input logic sbit, input logic [1:0] wval);
		item_t it;
		it.kind           = kind;
		it.site_x         = x;
		it.site_y         = y;
		it.neighbour_pick = pick;
		it.first_draw     = d1;
		it.second_draw    = d2;
		it.spin_bit       = sbit;
		it.write_value    = wval;
		queued_attempts.push_back(it);
	endtask

	task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx,
		input logic [REG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		thresholds[idx] = value;
	endtask

	// Returns once every queued item has been transferred and answered.
	task automatic wait_until_drained();
		do
			@(negedge clk);
		while (queued_attempts.size() != 0 || attempt_ch.valid || expected_updates.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Most coordinates fall in a six-wide window across the wrap.
	function automatic logic [COORD_W-1:0] lattice_coord();
		if ($urandom_range(0, 99) < 85)
			return COORD_W'(253 + $urandom_range(0, 5));
		return COORD_W'($urandom);
	endfunction

	// Draws cluster on the threshold boundary and the ends of the range.
	function automatic logic [DRAW_W-1:0] edge_draw(input logic [REG_W-1:0] thresh);
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return DRAW_MAX;
			2:       return thresh[DRAW_W-1:0];
			3:       return thresh[DRAW_W-1:0] - 1'b1;
			default: return $urandom;
		endcase
	endfunction

	// Input transfer: predict the result at the edge where the item is taken.
	always @(posedge clk) begin
		if (arst_n && attempt_ch.valid && attempt_ch.ready)
			expected_updates.push_back(apply_site_rules(attempt_ch.data));
		item_taken <= arst_n && attempt_ch.valid && attempt_ch.ready;
	end

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin : sender
		logic  next_valid;
		item_t next_item;
		next_valid = attempt_ch.valid;
		next_item  = attempt_ch.data;
		if (attempt_ch.valid !== 1'b1 || item_taken) begin
			next_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (queued_attempts.size() > 0) begin
				next_item  = queued_attempts.pop_front();
				next_valid = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
		attempt_ch.valid <= next_valid;
		attempt_ch.data  <= next_item;
	end

	// Receiver: switches among stall modes, with one long hold-off.
	always @(negedge clk) begin : receiver
		logic take;
		if (hold_left > 0) begin
			hold_left--;
			take = 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			take      = 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode    = stall_mode_t'($urandom_range(0, 2));
				mode_left     = $urandom_range(16, 96);
				stall_pattern = 16'($urandom);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				STALL_NONE:   take = 1'b1;
				STALL_RANDOM: take = ($urandom_range(0, 3) != 0);
				default: begin
					take          = stall_pattern[0];
					stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
				end
			endcase
		end
		result_ch.ready <= take;
	end

	task automatic compare_field(input string what, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	// Result transfer: compare with the oldest prediction.
	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (expected_updates.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %p",
					$time, result_ch.data);
				mismatch_count++;
			end else begin
				want = expected_updates.pop_front();
				compare_field("new_site", want.new_site, result_ch.data.new_site);
				compare_field("changed", want.changed, result_ch.data.changed);
				compare_field("occupied_total", want.occupied_total,
					result_ch.data.occupied_total);
				compare_field("up_total", want.up_total, result_ch.data.up_total);
				compare_field("down_total", want.down_total, result_ch.data.down_total);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("testbench failed");
		$finish;
	end

	initial begin : stimulus
		item_t            it;
		logic [REG_W-1:0] value;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		foreach (site_model[i])
			site_model[i] = SITE_EMPTY;
		occupied_model = '0;
		up_model       = '0;
		down_model     = '0;
		thresholds[REG_BIRTH]      = RST_BIRTH;
		thresholds[REG_DEATH]      = RST_DEATH;
		thresholds[REG_DIFF]       = RST_DIFF;
		thresholds[REG_FLIP_ONE]   = RST_FLIP_ONE;
		thresholds[REG_FLIP_TWO]   = RST_FLIP_TWO;
		thresholds[REG_FLIP_THREE] = RST_FLIP_THREE;
		thresholds[REG_FLIP_FOUR]  = RST_FLIP_FOUR;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		// The lattice clearing pass holds input ready low.
		do
			@(negedge clk);
		while (attempt_ch.ready !== 1'b1);

		// Reset thresholds: births always pass, no deaths, spins always taken.
		@(posedge clk);
		queue_item(KIND_ATTEMPT, 8'd0, 8'd0, NB_Y_MINUS, DRAW_MAX, DRAW_MAX, 1'b0, SITE_UP);
		queue_item(KIND_WRITE, 8'd0, 8'd255, NB_Y_PLUS, '0, '0, 1'b0, SITE_UP);
		queue_item(KIND_ATTEMPT, 8'd0, 8'd0, NB_Y_MINUS, DRAW_MAX, DRAW_MAX, 1'b1, SITE_EMPTY);
		queue_item(KIND_WRITE, 8'd255, 8'd0, NB_X_PLUS, DRAW_MAX, '0, 1'b1, SITE_DOWN);
		queue_item(KIND_ATTEMPT, 8'd255, 8'd1, NB_Y_MINUS, '0, '0, 1'b0, SITE_EMPTY);
		queue_item(KIND_WRITE, 8'd1, 8'd0, NB_X_MINUS, '0, '0, 1'b0, SITE_UNDIFF);
		queue_item(KIND_ATTEMPT, 8'd1, 8'd0, NB_Y_PLUS, '0, DRAW_MAX, 1'b1, SITE_DOWN);
		queue_item(KIND_WRITE, 8'd0, 8'd1, NB_Y_MINUS, '0, '0, 1'b0, SITE_UNDIFF);
		queue_item(KIND_ATTEMPT, 8'd0, 8'd1, NB_X_PLUS, '0, DRAW_MAX, 1'b0, SITE_UP);
		// Spin sum of zero around the corner site: it flips whatever the draw.
		queue_item(KIND_ATTEMPT, 8'd0, 8'd0, NB_Y_PLUS, '0, DRAW_MAX, 1'b0, SITE_EMPTY);
		queue_item(KIND_ATTEMPT, 8'd254, 8'd0, NB_X_PLUS, 32'h8000_0000, '0, 1'b0, SITE_EMPTY);
		queue_item(KIND_ATTEMPT, 8'd255, 8'd255, NB_Y_PLUS, 32'h1234_5678, '0, 1'b1, SITE_EMPTY);
		queue_item(KIND_ATTEMPT, 8'd2, 8'd0, NB_X_MINUS, 32'h7FFF_FFFF, '0, 1'b0, SITE_EMPTY);
		queue_item(KIND_WRITE, 8'd2, 8'd0, NB_Y_MINUS, '0, '0, 1'b0, SITE_EMPTY);
		queue_item(KIND_WRITE, 8'd128, 8'd127, NB_Y_MINUS, '0, '0, 1'b0, SITE_EMPTY);
		// Surrounded by down spins: the aligned-field flip test at its lowest draw.
		queue_item(KIND_ATTEMPT, 8'd255, 8'd0, NB_X_MINUS, DRAW_MAX, '0, 1'b0, SITE_EMPTY);
		queue_item(KIND_ATTEMPT, 8'd255, 8'd0, NB_X_MINUS, '0, DRAW_MAX, 1'b0, SITE_EMPTY);
		queue_item(KIND_ATTEMPT, 8'd255, 8'd0, NB_X_MINUS, '0, DRAW_MAX, 1'b0, SITE_EMPTY);
		wait_until_drained();

		// Every threshold at zero: no test passes, only neutral flips happen.
		for (int i = 0; i < NUM_REGS; i++)
			write_threshold(CFG_IDX_W'(i), '0);
		@(posedge clk);
		queue_item(KIND_ATTEMPT, 8'd2, 8'd0, NB_X_MINUS, '0, '0, 1'b1, SITE_EMPTY);
		queue_item(KIND_WRITE, 8'd5, 8'd5, NB_Y_MINUS, '0, '0, 1'b0, SITE_UNDIFF);
		queue_item(KIND_ATTEMPT, 8'd5, 8'd5, NB_Y_MINUS, '0, '0, 1'b1, SITE_EMPTY);
		queue_item(KIND_ATTEMPT, 8'd255, 8'd0, NB_Y_MINUS, '0, '0, 1'b0, SITE_EMPTY);
		queue_item(KIND_ATTEMPT, 8'd0, 8'd0, NB_Y_MINUS, '0, '0, 1'b0, SITE_EMPTY);
		wait_until_drained();

		// Certain death: it wins over a neutral flip and empties an undifferentiated site.
		write_threshold(REG_DEATH, ALWAYS_PASS);
		@(posedge clk);
		queue_item(KIND_ATTEMPT, 8'd0, 8'd0, NB_Y_MINUS, DRAW_MAX, '0, 1'b0, SITE_EMPTY);
		queue_item(KIND_ATTEMPT, 8'd5, 8'd5, NB_Y_MINUS, DRAW_MAX, '0, 1'b1, SITE_EMPTY);
		queue_item(KIND_WRITE, 8'd255, 8'd255, NB_Y_MINUS, '0, '0, 1'b0, SITE_UP);
		wait_until_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				case ($urandom_range(0, 3))
					0:       value = '0;
					1:       value = ALWAYS_PASS;
					default: value = {1'b0, 32'($urandom)};
				endcase
				write_threshold(CFG_IDX_W'(i), value);
			end
			@(posedge clk);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				it.kind           = ($urandom_range(0, 3) == 0) ? KIND_WRITE : KIND_ATTEMPT;
				it.site_x         = lattice_coord();
				it.site_y         = lattice_coord();
				it.neighbour_pick = 2'($urandom);
				it.first_draw     = edge_draw($urandom_range(0, 1) ?
					thresholds[REG_BIRTH] : thresholds[REG_DEATH]);
				it.second_draw    = edge_draw(thresholds[int'(REG_DIFF) + $urandom_range(0, 4)]);
				it.spin_bit       = 1'($urandom);
				it.write_value    = 2'($urandom);
				queued_attempts.push_back(it);
			end
			wait_until_drained();
		end

		if (mismatch_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ----- contact_ising_lattice_update_core.f -----
hdl/cilu_pkg.sv
hdl/cilu_channels.sv
hdl/contact_ising_lattice_update_core.sv
tb/sv/testbench.sv
